/* hdl/assert_macros.svh */
// Assertion helpers for the LCS unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that an antecedent implies a consequent on the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// check a condition that holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

/* hdl/lcs_pkg.sv */
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants and types of the LCS length and traceback unit.
// ----------------------------------------------------------------------------
`default_nettype none
package lcs_pkg;
   localparam int MAX_LEN = 64;
   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int DIR_W = 2;
   localparam logic [DIR_W-1:0] DIR_DIAG = 2'd1;
   localparam logic [DIR_W-1:0] DIR_UP = 2'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT = 2'd3;
   localparam int QDEPTH = 2;

   // transaction from the load front to the compute back
   typedef struct packed {
      logic [31:0] a_value;
      logic [31:0] b_value;
      logic        last;
   } pair_type;

   typedef struct packed {
      logic [31:0]      element;
      logic [CNT_W-1:0] length;
      logic             is_empty;
      logic             overflow;
      logic             end_of_run;
   } result_type;
endpackage
`default_nettype wire

/* hdl/lcs_length_and_traceback_unit.sv */
// ----------------------------------------------------------------------------
// lcs_length_and_traceback_unit: LCS length and traceback over streamed pairs.
// Loads a pair per cycle while req_tready; after the last of N pairs, traces
// back (S <= 2N-1 steps), then emits a result per cycle while rsp_tready;
// loads again after the final result. Reset (synchronous, active high) clears
// ----------------------------------------------------------------------------
// load count, overflow flag and control; sequence and table stores keep data.
`default_nettype none
`include "assert_macros.svh"
module lcs_length_and_traceback_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [63:0]  req_tdata,   // a_value[31:0], b_value[63:32]
   input  wire          req_tlast,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [39:0]  rsp_tdata,   // element[31:0], length[38:32], zero[39]
   output logic [7:0]   rsp_tuser,   // is_empty[0], overflow[1], zero[7:2]
   output logic         rsp_tlast
);
   import lcs_pkg::*;
   pair_type qin, qout;
   logic qv, qr;
   result_type res;
   logic empty_ok;

   assign qin.a_value = req_tdata[31:0];
   assign qin.b_value = req_tdata[63:32];
   assign qin.last = req_tlast;

   // front: hold incoming transactions while the back computes; a request
   // transaction is stored in the queue before it reaches the engine
   lcs_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(qin),
      .out_valid(qv), .out_ready(qr), .out_data(qout)
   );

   // back: store, clear the row, fill the tables, trace (S_TWAIT then S_TRACE
   // per step), emit (one result a cycle while rsp_tready is high)
   lcs_engine u_engine (
      .clock(clock), .reset(reset),
      .in_valid(qv), .in_ready(qr), .in_data(qout),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(res)
   );

   assign rsp_tdata = {1'b0, res.length, res.element};
   assign rsp_tuser = {6'b0, res.overflow, res.is_empty};
   assign rsp_tlast = res.end_of_run;

   // an empty run is a single zero-length transaction
   assign empty_ok = !rsp_tvalid || !res.is_empty || (res.length == '0 && res.end_of_run);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp changed")
   `ASSERT_ALWAYS(a_empty_len, clock, reset, empty_ok, "empty result malformed")
endmodule
`default_nettype wire

/* hdl/lcs_queue.sv */
// ----------------------------------------------------------------------------
// lcs_queue
// Small FIFO that parts the load front from the compute back.
// ----------------------------------------------------------------------------
`default_nettype none
module lcs_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  lcs_pkg::pair_type   in_data,
   output logic                out_valid,
   input  wire                 out_ready,
   output lcs_pkg::pair_type   out_data
);
   import lcs_pkg::*;
   pair_type mem_ff [QDEPTH];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'(QDEPTH));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule
`default_nettype wire

/* hdl/lcs_engine.sv */
// ----------------------------------------------------------------------------
// lcs_engine
// Stores pairs, fills the score and direction tables one cell a cycle,
// walks back and emits the subsequence in forward order.
// ----------------------------------------------------------------------------
`default_nettype none
module lcs_engine (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  lcs_pkg::pair_type    in_data,
   output logic                 out_valid,
   input  wire                  out_ready,
   output lcs_pkg::result_type  out_data
);
   import lcs_pkg::*;

   typedef enum logic [5:0] {
      S_LOAD  = 6'b000001,
      S_CLR   = 6'b000010,
      S_FILL  = 6'b000100,
      S_TRACE = 6'b001000,
      S_TWAIT = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type st_ff, st_in;
   logic [31:0] aseq [MAX_LEN];
   logic [31:0] bseq [MAX_LEN];
   logic [DIR_W-1:0] dtab [MAX_LEN*MAX_LEN];
   logic [31:0] tbuf [MAX_LEN];
   logic [CNT_W-1:0] score_ff [MAX_LEN+1];
   logic [CNT_W-1:0] cnt_ff, cnt_in, n_ff, n_in;
   logic ovf_ff, ovf_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CNT_W-1:0] diag_ff, diag_in;
   logic [CNT_W-1:0] above_ff, left_ff;
   logic [31:0] ai_ff, bj_ff;
   logic [DIR_W-1:0] d_ff;
   logic [31:0] ax_ff;
   logic tv_ff, tv_in;
   result_type r_ff;
   logic accept, store;
   logic [CNT_W-1:0] above, left;
   logic [DIR_W-1:0] dir;
   logic [CNT_W-1:0] sc;

   assign in_ready = (st_ff == S_LOAD);
   assign accept = in_valid && in_ready;
   assign store = accept && (cnt_ff != CNT_W'(MAX_LEN));
   assign out_valid = tv_ff;
   assign out_data = r_ff;
   // above comes from a registered row read; left is the cell just computed
   assign above = above_ff;
   assign left = left_ff;

   always_comb begin
      if (ai_ff == bj_ff) begin
         dir = DIR_DIAG;
         sc = diag_ff + 1'b1;
      end else if (above >= left) begin
         dir = DIR_UP;
         sc = above;
      end else begin
         dir = DIR_LEFT;
         sc = left;
      end
   end

   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      ovf_in = ovf_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      diag_in = diag_ff;
      tv_in = tv_ff;
      case (st_ff)
         S_LOAD: begin
            if (accept) begin
               if (store) cnt_in = cnt_ff + 1'b1;
               else ovf_in = 1'b1;
               if (in_data.last) begin
                  n_in = store ? cnt_ff + 1'b1 : cnt_ff;
                  j_in = '0;
                  st_in = S_CLR;
               end
            end
         end
         S_CLR: begin
            j_in = j_ff + 1'b1;
            if (j_ff == n_ff) begin
               i_in = CNT_W'(1);
               j_in = CNT_W'(1);
               diag_in = '0;
               st_in = S_FILL;
            end
         end
         S_FILL: begin
            // one cell per cycle; a-element and b-element are read into registers ahead of their cell
            diag_in = above;
            if (j_ff == n_ff) begin
               j_in = CNT_W'(1);
               diag_in = '0;
               i_in = i_ff + 1'b1;
               if (i_ff == n_ff) begin
                  i_in = n_ff;
                  j_in = n_ff;
                  k_in = '0;
                  st_in = S_TWAIT;
               end
            end else j_in = j_ff + 1'b1;
         end
         S_TWAIT: st_in = S_TRACE;
         S_TRACE: begin
            if (i_ff == '0 || j_ff == '0) begin
               st_in = S_EMIT;
               tv_in = 1'b0;
            end else begin
               if (d_ff == DIR_DIAG) begin
                  k_in = k_ff + 1'b1;
                  i_in = i_ff - 1'b1;
                  j_in = j_ff - 1'b1;
               end else if (d_ff == DIR_UP) i_in = i_ff - 1'b1;
               else j_in = j_ff - 1'b1;
               st_in = S_TWAIT;
            end
         end
         S_EMIT: begin
            if (!tv_ff || out_ready) begin
               if (tv_ff && r_ff.end_of_run) begin
                  tv_in = 1'b0;
                  cnt_in = '0;
                  ovf_in = 1'b0;
                  st_in = S_LOAD;
               end else begin
                  tv_in = 1'b1;
                  if (k_ff != '0) k_in = k_ff - 1'b1;
               end
            end
         end
         default: st_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         tv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         tv_ff <= tv_in;
      end
      n_ff <= n_in;
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      diag_ff <= diag_in;
      if (store) begin
         aseq[cnt_ff[IDX_W-1:0]] <= in_data.a_value;
         bseq[cnt_ff[IDX_W-1:0]] <= in_data.b_value;
      end
      if (st_ff == S_CLR) score_ff[j_ff] <= '0;
      if (st_ff == S_FILL) begin
         score_ff[j_ff] <= sc;
         dtab[{i_ff[IDX_W-1:0] - 1'b1, j_ff[IDX_W-1:0] - 1'b1}] <= dir;
      end
      // row operands for the next cell; the first row sees a cleared row above
      above_ff <= (st_ff == S_FILL) ? score_ff[j_in] : '0;
      if (st_ff == S_FILL && j_ff != n_ff) left_ff <= sc;
      else left_ff <= '0;
      // operand prefetch for the next cell
      ai_ff <= aseq[i_in[IDX_W-1:0] - 1'b1];
      bj_ff <= bseq[j_in[IDX_W-1:0] - 1'b1];
      d_ff <= dtab[{i_in[IDX_W-1:0] - 1'b1, j_in[IDX_W-1:0] - 1'b1}];
      ax_ff <= aseq[i_ff[IDX_W-1:0] - 1'b1];
      if (st_ff == S_TRACE && i_ff != '0 && j_ff != '0 && d_ff == DIR_DIAG)
         tbuf[k_ff[IDX_W-1:0]] <= ax_ff;
      // capture length when traceback ends
      if (st_ff == S_TRACE && st_in == S_EMIT) r_ff.length <= k_ff;
      if (st_ff == S_EMIT && (!tv_ff || out_ready) && !(tv_ff && r_ff.end_of_run)) begin
         r_ff.element <= (r_ff.length == '0) ? 32'd0 : tbuf[k_ff[IDX_W-1:0] - 1'b1];
         r_ff.is_empty <= (r_ff.length == '0);
         r_ff.overflow <= ovf_ff;
         r_ff.end_of_run <= (k_ff <= CNT_W'(1));
      end
   end
endmodule
`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// LCS length and traceback unit testbench
// Streams pairs of sequences into the unit, predicts the common subsequence
// of each run, and compares every result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import lcs_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 64;

   typedef struct {
      logic [31:0] element;
      logic [6:0]  length;
      logic        is_empty;
      logic        overflow;
      logic        end_of_run;
   } lcs_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [7:0]  rsp_tuser;
   logic        rsp_tlast;

   // predictor state: sequences of the run being loaded
   logic [31:0] seq_a[$];
   logic [31:0] seq_b[$];
   logic        dropped_pair;
   lcs_result_type expected_results[$];

   int  error_count = 0;
   int  idle_cycles = 0;
   bit  sink_idle_en = 1'b1;
   bit  source_idle_en = 1'b1;
   int  sink_hold_cycles = 0;

   lcs_length_and_traceback_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Fill the score and direction tables for the loaded run, walk back from
   // the corner and queue the subsequence in forward order.
   task automatic predict_subsequence();
      int          n;
      int          x;
      int          y;
      int          above;
      int          left;
      int          diag;
      int          score[MAX_LEN+1];
      logic [1:0]  dir[MAX_LEN][MAX_LEN];
      logic [31:0] found[$];
      lcs_result_type r;
      n = seq_a.size();
      for (int j = 0; j <= MAX_LEN; j++) score[j] = 0;
      for (int i = 1; i <= n; i++) begin
         diag = 0;
         for (int j = 1; j <= n; j++) begin
            above = score[j];
            left  = score[j-1];
            if (seq_a[i-1] == seq_b[j-1]) begin
               score[j] = diag + 1;
               dir[i-1][j-1] = DIR_DIAG;
            end else if (above >= left) begin
               score[j] = above;
               dir[i-1][j-1] = DIR_UP;
            end else begin
               score[j] = left;
               dir[i-1][j-1] = DIR_LEFT;
            end
            diag = above;
         end
      end
      x = n;
      y = n;
      while (x > 0 && y > 0) begin
         if (dir[x-1][y-1] == DIR_DIAG) begin
            found.push_front(seq_a[x-1]);
            x--;
            y--;
         end else if (dir[x-1][y-1] == DIR_UP) begin
            x--;
         end else begin
            y--;
         end
      end
      if (found.size() == 0) begin
         r = '{32'd0, 7'd0, 1'b1, dropped_pair, 1'b1};
         expected_results.push_back(r);
      end
      foreach (found[k]) begin
         r = '{found[k], 7'(found.size()), 1'b0, dropped_pair, k == found.size() - 1};
         expected_results.push_back(r);
      end
      seq_a.delete();
      seq_b.delete();
      dropped_pair = 1'b0;
   endtask

   // Offer one pair; hold it until accepted, then update the predictor.
   // Valid stays up after acceptance; the next send or a drain drops it.
   task automatic send_pair(input logic [31:0] a, input logic [31:0] b,
                            input logic last);
      while (source_idle_en && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (seq_a.size() < MAX_LEN) begin
         seq_a.push_back(a);
         seq_b.push_back(b);
      end else begin
         dropped_pair = 1'b1;
      end
      if (last) predict_subsequence();
   endtask

   // Stop offering and wait until every expected result has come.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Send one run; values drawn from a small alphabet so matches are common, or from the full range when alphabet is 0.
   task automatic send_random_run(input int len, input int alphabet);
      logic [31:0] a;
      logic [31:0] b;
      for (int i = 0; i < len; i++) begin
         a = (alphabet == 0) ? $urandom : $urandom_range(alphabet - 1);
         b = (alphabet == 0) ? $urandom : $urandom_range(alphabet - 1);
         if ($urandom_range(3) == 0) a = -a;
         if ($urandom_range(3) == 0) b = -b;
         send_pair(a, b, i == len - 1);
      end
   endtask

   task automatic test_single_pairs();
      send_pair(32'h8000_0000, 32'h8000_0000, 1'b1);  // match at extreme low
      send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);  // no match: empty
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
   endtask

   task automatic test_tie_breaks();
      // ties between above and left go up; left is taken only when it is larger
      send_pair(32'd1, 32'd2, 1'b0);
      send_pair(32'd2, 32'd1, 1'b0);
      send_pair(32'd3, 32'd3, 1'b1);
      send_pair(32'd5, 32'd7, 1'b0);
      send_pair(32'd5, 32'd5, 1'b0);
      send_pair(32'd7, 32'd9, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_overflow();
      // full run of identical sequences, then extra pairs dropped, last too
      for (int i = 0; i < MAX_LEN; i++) send_pair(32'(i * 3 - 90), 32'(i * 3 - 90), 1'b0);
      send_pair(32'd11, 32'd11, 1'b0);
      send_pair(32'd12, 32'd12, 1'b1);
      for (int i = 0; i < MAX_LEN + 2; i++) send_pair(32'd4, 32'd5, i == MAX_LEN + 1);
   endtask

   task automatic test_backpressure();
      // receiver holds off while the sender keeps offering
      sink_hold_cycles = 600;
      for (int r = 0; r < 4; r++) send_random_run(12, 3);
      wait_for_drain();
   endtask

   task automatic test_random_runs();
      int len;
      int sent;
      sent = 0;
      while (sent < 240) begin
         if (sent > 60 && sent < 160) begin
            source_idle_en = 1'b0;
            sink_idle_en   = 1'b0;
         end else begin
            source_idle_en = 1'b1;
            sink_idle_en   = 1'b1;
         end
         len = ($urandom_range(15) == 0) ? $urandom_range(MAX_LEN, 40)
                                         : $urandom_range(12, 1);
         case ($urandom_range(3))
            0: send_random_run(len, 0);
            1: send_random_run(len, 2);
            default: send_random_run(len, 6);
         endcase
         sent += len;
      end
   endtask

   // Receiver: random stalls, plus a long hold-off when requested.
   always @(posedge clock) begin
      if (sink_hold_cycles > 0) begin
         sink_hold_cycles <= sink_hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(sink_idle_en && $urandom_range(99) < 12);
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      lcs_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with no expectation pending", $realtime);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[31:0] !== want.element)
               report_mismatch("element", rsp_tdata[31:0], want.element);
            if (rsp_tdata[38:32] !== want.length)
               report_mismatch("length", 32'(rsp_tdata[38:32]), 32'(want.length));
            if (rsp_tuser[0] !== want.is_empty)
               report_mismatch("is_empty", 32'(rsp_tuser[0]), 32'(want.is_empty));
            if (rsp_tuser[1] !== want.overflow)
               report_mismatch("overflow", 32'(rsp_tuser[1]), 32'(want.overflow));
            if (rsp_tlast !== want.end_of_run)
               report_mismatch("end_of_run", 32'(rsp_tlast), 32'(want.end_of_run));
         end
      end
   end

   // Watchdog: count cycles with no transaction on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      dropped_pair = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_pairs();
      test_tie_breaks();
      test_overflow();
      test_backpressure();
      test_random_runs();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
